// ===== design/fsp_pkg.sv =====
package fsp_pkg;

  localparam int unsigned WORD_W    = 43;
  localparam int unsigned NUM_W     = 8;
  localparam int unsigned PROD_W    = 12;
  localparam int unsigned CONV_W    = 12;
  localparam int unsigned NUM_MAX   = 255;

  // Bit positions inside the packed word
  localparam int unsigned PCT_POS   = 12;
  localparam int unsigned H_POS     = 13;
  localparam int unsigned HH_POS    = 14;
  localparam int unsigned L_POS     = 15;
  localparam int unsigned LL_POS    = 16;
  localparam int unsigned J_POS     = 17;
  localparam int unsigned Z_POS     = 18;
  localparam int unsigned T_POS     = 19;
  localparam int unsigned HASH_POS  = 20;
  localparam int unsigned ZERO_POS  = 21;
  localparam int unsigned MINUS_POS = 22;
  localparam int unsigned PLUS_POS  = 23;
  localparam int unsigned SPACE_POS = 24;
  localparam int unsigned DOT_POS   = 25;
  localparam int unsigned WIDTH_POS = 27;
  localparam int unsigned PREC_POS  = 35;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_Z     = 8'h7A;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] word;
    logic              clamp;
    logic              empty;
  } fsp_res_t;

  function automatic logic [CONV_W-1:0] conv_bits(input logic [7:0] c);
    logic [CONV_W-1:0] r;
    r = '0;
    unique case (c)
      8'h73:        r[0]  = 1'b1;  // s
      8'h53:        r[1]  = 1'b1;  // S
      8'h70:        r[2]  = 1'b1;  // p
      8'h64, 8'h69: r[3]  = 1'b1;  // d i
      8'h44:        r[4]  = 1'b1;  // D
      8'h6F:        r[5]  = 1'b1;  // o
      8'h4F:        r[6]  = 1'b1;  // O
      8'h75:        r[7]  = 1'b1;  // u
      8'h55:        r[8]  = 1'b1;  // U
      8'h78:        r[9]  = 1'b1;  // x
      8'h58:        r[10] = 1'b1;  // X
      8'h63, 8'h43: r[11] = 1'b1;  // c C
      default:      r     = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/fsp_core.sv =====
module fsp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en_i,
  input  logic [7:0]        ch_i,
  input  logic              start_i,
  output fsp_pkg::fsp_res_t res_o
);

  logic [fsp_pkg::WORD_W-1:0] bits_r, bits_nxt;
  logic [fsp_pkg::NUM_W-1:0]  acc_r, acc_nxt;
  logic                       innum_r, innum_nxt;
  logic                       mad_r, mad_nxt;
  logic                       active_r, active_nxt;
  logic                       clamp_r, clamp_nxt;
  logic                       first_r, first_nxt;

  logic                       is_digit;
  logic                       is_letter;
  logic [fsp_pkg::NUM_W-1:0]  digit;
  logic [fsp_pkg::PROD_W-1:0] prod;
  logic                       emit;
  logic                       emit_empty;
  logic [fsp_pkg::WORD_W-1:0] word;

  assign is_digit  = (ch_i >= fsp_pkg::CH_0) && (ch_i <= fsp_pkg::CH_9);
  assign is_letter = ((ch_i >= fsp_pkg::CH_LC_A) && (ch_i <= fsp_pkg::CH_LC_Z)) ||
                     ((ch_i >= fsp_pkg::CH_UC_A) && (ch_i <= fsp_pkg::CH_UC_Z));
  assign digit     = ch_i - fsp_pkg::CH_0;
  // acc * 10 + digit
  assign prod      = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {4'b0000, digit};

  always_comb begin
    bits_nxt   = bits_r;
    acc_nxt    = acc_r;
    innum_nxt  = innum_r;
    mad_nxt    = mad_r;
    active_nxt = active_r;
    clamp_nxt  = clamp_r;
    first_nxt  = first_r;
    emit       = 1'b0;
    emit_empty = 1'b0;
    word       = '0;

    priority if (start_i) begin
      bits_nxt   = '0;
      acc_nxt    = '0;
      innum_nxt  = 1'b0;
      mad_nxt    = 1'b0;
      clamp_nxt  = 1'b0;
      active_nxt = 1'b1;
      first_nxt  = 1'b1;
    end else if (active_r && innum_r && is_digit) begin
      if (prod > fsp_pkg::PROD_W'(fsp_pkg::NUM_MAX)) begin
        acc_nxt   = fsp_pkg::NUM_W'(fsp_pkg::NUM_MAX);
        clamp_nxt = 1'b1;
      end else begin
        acc_nxt = prod[fsp_pkg::NUM_W-1:0];
      end
      first_nxt = 1'b0;
    end else if (active_r) begin
      // close a pending number into width or precision
      if (innum_r) begin
        if (bits_r[fsp_pkg::DOT_POS] && !mad_r) begin
          bits_nxt[fsp_pkg::PREC_POS +: fsp_pkg::NUM_W] =
            bits_r[fsp_pkg::PREC_POS +: fsp_pkg::NUM_W] | acc_r;
        end else begin
          bits_nxt[fsp_pkg::WIDTH_POS +: fsp_pkg::NUM_W] =
            bits_r[fsp_pkg::WIDTH_POS +: fsp_pkg::NUM_W] | acc_r;
        end
        innum_nxt = 1'b0;
        acc_nxt   = '0;
      end
      first_nxt = 1'b0;

      unique case (ch_i)
        fsp_pkg::CH_NUL: begin
          emit       = 1'b1;
          emit_empty = first_r;
        end
        fsp_pkg::CH_HASH:  bits_nxt[fsp_pkg::HASH_POS]  = 1'b1;
        fsp_pkg::CH_0:     bits_nxt[fsp_pkg::ZERO_POS]  = 1'b1;
        fsp_pkg::CH_MINUS: begin
          bits_nxt[fsp_pkg::MINUS_POS] = 1'b1;
          if (bits_nxt[fsp_pkg::DOT_POS]) begin
            mad_nxt = 1'b1;
          end
        end
        fsp_pkg::CH_PLUS:  bits_nxt[fsp_pkg::PLUS_POS]  = 1'b1;
        fsp_pkg::CH_SPACE: bits_nxt[fsp_pkg::SPACE_POS] = 1'b1;
        fsp_pkg::CH_DOT: begin
          bits_nxt[fsp_pkg::DOT_POS] = 1'b1;
          mad_nxt                    = 1'b0;
        end
        fsp_pkg::CH_H: begin
          if (bits_nxt[fsp_pkg::H_POS]) begin
            bits_nxt[fsp_pkg::H_POS]  = 1'b0;
            bits_nxt[fsp_pkg::HH_POS] = 1'b1;
          end else if (!bits_nxt[fsp_pkg::HH_POS]) begin
            bits_nxt[fsp_pkg::H_POS] = 1'b1;
          end
        end
        fsp_pkg::CH_L: begin
          if (bits_nxt[fsp_pkg::L_POS]) begin
            bits_nxt[fsp_pkg::L_POS]  = 1'b0;
            bits_nxt[fsp_pkg::LL_POS] = 1'b1;
          end else if (!bits_nxt[fsp_pkg::LL_POS]) begin
            bits_nxt[fsp_pkg::L_POS] = 1'b1;
          end
        end
        fsp_pkg::CH_J: bits_nxt[fsp_pkg::J_POS] = 1'b1;
        fsp_pkg::CH_Z: bits_nxt[fsp_pkg::Z_POS] = 1'b1;
        fsp_pkg::CH_T: bits_nxt[fsp_pkg::T_POS] = 1'b1;
        fsp_pkg::CH_PCT: begin
          bits_nxt[fsp_pkg::PCT_POS] = 1'b1;
          emit                       = 1'b1;
        end
        default: begin
          if (is_digit) begin
            innum_nxt = 1'b1;
            acc_nxt   = digit;
          end else if (is_letter) begin
            bits_nxt[fsp_pkg::CONV_W-1:0] =
              bits_nxt[fsp_pkg::CONV_W-1:0] | fsp_pkg::conv_bits(ch_i);
            emit = 1'b1;
          end
        end
      endcase

      if (emit) begin
        word = bits_nxt;
        // '-' overrides '0'
        if (word[fsp_pkg::MINUS_POS]) begin
          word[fsp_pkg::ZERO_POS] = 1'b0;
        end
        bits_nxt   = '0;
        acc_nxt    = '0;
        innum_nxt  = 1'b0;
        mad_nxt    = 1'b0;
        active_nxt = 1'b0;
        clamp_nxt  = 1'b0;
        first_nxt  = 1'b0;
      end
    end else begin
      // no open spec: drop the character
    end
  end

  always_comb begin
    res_o.vld   = emit;
    res_o.word  = word;
    res_o.clamp = clamp_r;
    res_o.empty = emit_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= '0;
      acc_r    <= '0;
      innum_r  <= 1'b0;
      mad_r    <= 1'b0;
      active_r <= 1'b0;
      clamp_r  <= 1'b0;
      first_r  <= 1'b0;
    end else if (en_i) begin
      bits_r   <= bits_nxt;
      acc_r    <= acc_nxt;
      innum_r  <= innum_nxt;
      mad_r    <= mad_nxt;
      active_r <= active_nxt;
      clamp_r  <= clamp_nxt;
      first_r  <= first_nxt;
    end
  end

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && start_i |=> active_r && first_r && !innum_r && (bits_r == '0))
    else $error("start did not open a clean spec");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && res_o.vld |=> !active_r && !clamp_r)
    else $error("spec still open after result");

  a_num_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    innum_r |-> active_r)
    else $error("number pending with no open spec");

endmodule

// ===== design/format_spec_parser_top.sv =====
// Printf conversion specifier parser. Feed the characters of a format string one
// item per cycle, flagging the opening '%' with in_start_req; every character after
// it updates the packed specifier and a conversion letter, '%' or a NUL closes it
// and yields one result item (spec_word, value_clamped, empty_error). Other items
// yield nothing. Throughput is one character per cycle unless a closing character
// waits: it waits in the input register while an earlier result is held by
// out_stall; others pass. out_valid is driven by the result register, which the
// closing character reaches through the input register and the character update.
module format_spec_parser_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_ch,
  input  logic                       in_start_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fsp_pkg::WORD_W-1:0] out_spec_word,
  output logic                       out_value_clamped,
  output logic                       out_empty_error
);

  logic                       in_vld_r;
  logic [7:0]                 in_ch_r;
  logic                       in_start_r;
  logic                       out_vld_r;
  logic [fsp_pkg::WORD_W-1:0] out_word_r;
  logic                       out_clamp_r;
  logic                       out_empty_r;

  logic                       proc_en;
  logic                       in_acc;
  fsp_pkg::fsp_res_t          res;

  // items with no result advance even when the output is blocked
  assign proc_en  = in_vld_r && (!res.vld || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc_en;
  assign in_acc   = in_valid && !in_stall;

  fsp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (proc_en),
    .ch_i    (in_ch_r),
    .start_i (in_start_r),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (proc_en) begin
        in_vld_r <= 1'b0;
      end
      if (proc_en && res.vld) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_ch_r    <= in_ch;
      in_start_r <= in_start_req;
    end
    if (proc_en && res.vld) begin
      out_word_r  <= res.word;
      out_clamp_r <= res.clamp;
      out_empty_r <= res.empty;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_spec_word     = out_word_r;
  assign out_value_clamped = out_clamp_r;
  assign out_empty_error   = out_empty_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en && res.vld |-> !(out_vld_r && out_stall))
    else $error("result register overwritten while held");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc_en |=> in_vld_r && $stable(in_ch_r) && $stable(in_start_r))
    else $error("blocked input item lost");

  a_proc_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |-> in_vld_r)
    else $error("update with no item");

endmodule

// ===== tb/tb_format_spec_parser_top.sv =====
`timescale 1ns / 1ps

module tb_format_spec_parser_top;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TARGET_ITEMS   = 1500;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned QUIET_LO       = 800;
  localparam int unsigned QUIET_HI       = 1300;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       hold;   // wait for every pending spec to come out first
  } char_item_t;

  typedef struct packed {
    logic [fsp_pkg::WORD_W-1:0] word;
    logic                       clamp;
    logic                       empty;
  } spec_res_t;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_ch        = '0;
  logic                       in_start_req = 1'b0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [fsp_pkg::WORD_W-1:0] out_spec_word;
  logic                       out_value_clamped;
  logic                       out_empty_error;

  char_item_t pending_chars[$];
  spec_res_t  expected_specs[$];
  char_item_t drv_cur;
  logic       drv_next_v;
  int unsigned cyc;
  int unsigned quiet_cycles;
  int unsigned err_count;
  int unsigned n_items;

  // shadow parser state
  logic [fsp_pkg::WORD_W-1:0] sp_bits;
  logic [fsp_pkg::NUM_W-1:0]  sp_num;
  logic                       sp_in_num;
  logic                       sp_minus_dot;
  logic                       sp_active;
  logic                       sp_clamp;
  logic                       sp_first;

  format_spec_parser_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ch             (in_ch),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_spec_word     (out_spec_word),
    .out_value_clamped (out_value_clamped),
    .out_empty_error   (out_empty_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  function automatic logic [fsp_pkg::CONV_W-1:0] conv_code(input logic [7:0] c);
    case (c)
      "s":      return 12'h001;
      "S":      return 12'h002;
      "p":      return 12'h004;
      "d", "i": return 12'h008;
      "D":      return 12'h010;
      "o":      return 12'h020;
      "O":      return 12'h040;
      "u":      return 12'h080;
      "U":      return 12'h100;
      "x":      return 12'h200;
      "X":      return 12'h400;
      "c", "C": return 12'h800;
      default:  return '0;
    endcase
  endfunction

  task automatic clear_spec();
    sp_bits      = '0;
    sp_num       = '0;
    sp_in_num    = 1'b0;
    sp_minus_dot = 1'b0;
    sp_active    = 1'b0;
    sp_clamp     = 1'b0;
    sp_first     = 1'b0;
  endtask

  task automatic close_spec(input bit empty);
    spec_res_t r;
    r.word = sp_bits;
    // '-' overrides '0'
    if (r.word[fsp_pkg::MINUS_POS]) r.word[fsp_pkg::ZERO_POS] = 1'b0;
    r.clamp = sp_clamp;
    r.empty = empty;
    expected_specs.push_back(r);
    clear_spec();
  endtask

  task automatic length_pair(input int unsigned single, input int unsigned dbl);
    if (sp_bits[single]) begin
      sp_bits[single] = 1'b0;
      sp_bits[dbl]    = 1'b1;
    end else if (!sp_bits[dbl]) begin
      sp_bits[single] = 1'b1;
    end
  endtask

  task automatic parse_char(input char_item_t it);
    int acc;
    bit was_first;
    if (it.start) begin
      clear_spec();
      sp_active = 1'b1;
      sp_first  = 1'b1;
      return;
    end
    if (!sp_active) return;
    if (sp_in_num && it.ch >= fsp_pkg::CH_0 && it.ch <= fsp_pkg::CH_9) begin
      acc = int'(sp_num) * 10 + int'(it.ch - fsp_pkg::CH_0);
      if (acc > fsp_pkg::NUM_MAX) begin
        acc      = fsp_pkg::NUM_MAX;
        sp_clamp = 1'b1;
      end
      sp_num   = 8'(acc);
      sp_first = 1'b0;
      return;
    end
    if (sp_in_num) begin
      if (sp_bits[fsp_pkg::DOT_POS] && !sp_minus_dot)
        sp_bits[fsp_pkg::PREC_POS +: fsp_pkg::NUM_W] |= sp_num;
      else
        sp_bits[fsp_pkg::WIDTH_POS +: fsp_pkg::NUM_W] |= sp_num;
      sp_in_num = 1'b0;
      sp_num    = '0;
    end
    was_first = sp_first;
    sp_first  = 1'b0;
    case (it.ch)
      fsp_pkg::CH_NUL:   close_spec(was_first);
      fsp_pkg::CH_HASH:  sp_bits[fsp_pkg::HASH_POS] = 1'b1;
      fsp_pkg::CH_0:     sp_bits[fsp_pkg::ZERO_POS] = 1'b1;
      fsp_pkg::CH_MINUS: begin
        sp_bits[fsp_pkg::MINUS_POS] = 1'b1;
        if (sp_bits[fsp_pkg::DOT_POS]) sp_minus_dot = 1'b1;
      end
      fsp_pkg::CH_PLUS:  sp_bits[fsp_pkg::PLUS_POS] = 1'b1;
      fsp_pkg::CH_SPACE: sp_bits[fsp_pkg::SPACE_POS] = 1'b1;
      fsp_pkg::CH_DOT: begin
        sp_bits[fsp_pkg::DOT_POS] = 1'b1;
        sp_minus_dot              = 1'b0;
      end
      fsp_pkg::CH_H:     length_pair(fsp_pkg::H_POS, fsp_pkg::HH_POS);
      fsp_pkg::CH_L:     length_pair(fsp_pkg::L_POS, fsp_pkg::LL_POS);
      fsp_pkg::CH_J:     sp_bits[fsp_pkg::J_POS] = 1'b1;
      fsp_pkg::CH_Z:     sp_bits[fsp_pkg::Z_POS] = 1'b1;
      fsp_pkg::CH_T:     sp_bits[fsp_pkg::T_POS] = 1'b1;
      fsp_pkg::CH_PCT: begin
        sp_bits[fsp_pkg::PCT_POS] = 1'b1;
        close_spec(1'b0);
      end
      default: begin
        if (it.ch >= fsp_pkg::CH_1 && it.ch <= fsp_pkg::CH_9) begin
          sp_in_num = 1'b1;
          sp_num    = it.ch - fsp_pkg::CH_0;
        end else if ((it.ch >= fsp_pkg::CH_LC_A && it.ch <= fsp_pkg::CH_LC_Z) ||
                     (it.ch >= fsp_pkg::CH_UC_A && it.ch <= fsp_pkg::CH_UC_Z)) begin
          sp_bits[fsp_pkg::CONV_W-1:0] |= conv_code(it.ch);
          close_spec(1'b0);
        end
      end
    endcase
  endtask

  task automatic add_char(input logic [7:0] c, input bit s, input bit h);
    char_item_t it;
    it.ch    = c;
    it.start = s;
    it.hold  = h;
    pending_chars.push_back(it);
    n_items++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == 0, 1'b0);
  endtask

  task automatic add_number();
    int unsigned digits;
    digits = ($urandom_range(15) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
    add_char(fsp_pkg::CH_0 + 8'($urandom_range(1, 9)), 1'b0, 1'b0);
    repeat (digits - 1) add_char(fsp_pkg::CH_0 + 8'($urandom_range(9)), 1'b0, 1'b0);
  endtask

  task automatic add_spec(input bit h);
    string conv_chars = "sSpdiDoOuUxXcC";
    string flag_chars = "#0-+ ";
    int unsigned r;
    add_char(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : fsp_pkg::CH_PCT,
             1'b1, h);
    repeat ($urandom_range(3)) add_char(flag_chars[$urandom_range(4)], 1'b0, 1'b0);
    if ($urandom_range(1)) add_number();
    if ($urandom_range(2) == 0) begin
      add_char(fsp_pkg::CH_DOT, 1'b0, 1'b0);
      if ($urandom_range(3) == 0) add_char(fsp_pkg::CH_MINUS, 1'b0, 1'b0);
      if ($urandom_range(2) != 0) add_number();
    end
    // stray flags or a second number late in the spec
    if ($urandom_range(7) == 0) add_char(flag_chars[$urandom_range(4)], 1'b0, 1'b0);
    if ($urandom_range(9) == 0) add_number();
    case ($urandom_range(11))
      0: add_char(fsp_pkg::CH_H, 1'b0, 1'b0);
      1: repeat (2) add_char(fsp_pkg::CH_H, 1'b0, 1'b0);
      2: repeat (3) add_char(fsp_pkg::CH_H, 1'b0, 1'b0);
      3: add_char(fsp_pkg::CH_L, 1'b0, 1'b0);
      4: repeat (2) add_char(fsp_pkg::CH_L, 1'b0, 1'b0);
      5: repeat (3) add_char(fsp_pkg::CH_L, 1'b0, 1'b0);
      6: add_char(fsp_pkg::CH_J, 1'b0, 1'b0);
      7: add_char(fsp_pkg::CH_Z, 1'b0, 1'b0);
      8: add_char(fsp_pkg::CH_T, 1'b0, 1'b0);
      9: begin
        add_char(fsp_pkg::CH_H, 1'b0, 1'b0);
        add_char(fsp_pkg::CH_L, 1'b0, 1'b0);
      end
      default: ;
    endcase
    if ($urandom_range(7) == 0) add_char(8'($urandom_range(128, 255)), 1'b0, 1'b0);
    r = $urandom_range(19);
    if (r < 13) add_char(conv_chars[$urandom_range(13)], 1'b0, 1'b0);
    else if (r < 15) add_char(fsp_pkg::CH_PCT, 1'b0, 1'b0);
    else if (r < 17) add_char(fsp_pkg::CH_NUL, 1'b0, 1'b0);
    else if (r == 17) add_char(($urandom_range(1) ? fsp_pkg::CH_UC_A : fsp_pkg::CH_LC_A) +
                               8'($urandom_range(25)), 1'b0, 1'b0);
    else if (r == 19) add_char(8'($urandom_range(255)), 1'b0, 1'b0);
    // otherwise leave the spec open; the next start drops it
  endtask

  initial begin
    int unsigned hold_mark;
    bit h;
    clear_spec();
    hold_mark = 500;

    // idle byte, empty spec, literal percent
    add_char(8'hFF, 1'b0, 1'b0);
    add_char(fsp_pkg::CH_NUL, 1'b1, 1'b0);
    add_char(fsp_pkg::CH_NUL, 1'b0, 1'b0);
    add_text("%%");
    // every flag, saturated width, hh, minus over zero
    add_text("%0-# +999.hhx");
    // minus after dot sends the number to width; restart drops the open spec
    add_text("%.-7ll");
    add_char(8'hFF, 1'b1, 1'b0);
    add_char("Q", 1'b0, 1'b0);

    while (n_items < TARGET_ITEMS) begin
      h = n_items >= hold_mark;
      if (h) hold_mark += 500;
      if ($urandom_range(99) < 85) begin
        add_spec(h);
      end else begin
        repeat ($urandom_range(1, 8))
          add_char(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid || expected_specs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_format_spec_parser_top passed");
    end else begin
      $display("tb_format_spec_parser_top failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_ch        <= '0;
      in_start_req <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) parse_char(drv_cur);
      drv_next_v = 1'b0;
      if (pending_chars.size() != 0 && !take_break() &&
          !(pending_chars[0].hold && expected_specs.size() != 0)) begin
        drv_cur      = pending_chars.pop_front();
        drv_next_v   = 1'b1;
        in_ch        <= drv_cur.ch;
        in_start_req <= drv_cur.start;
      end
      in_valid <= drv_next_v;
    end
  end

  // monitor
  always @(posedge clk) begin
    spec_res_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_specs.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result item: spec_word %h clamped %b empty %b",
                   $time, out_spec_word, out_value_clamped, out_empty_error);
        end else begin
          e = expected_specs.pop_front();
          if (out_spec_word !== e.word) begin
            err_count++;
            $display("%0t: spec_word mismatch: expected %h, actual %h",
                     $time, e.word, out_spec_word);
          end
          if (out_value_clamped !== e.clamp) begin
            err_count++;
            $display("%0t: value_clamped mismatch: expected %b, actual %b",
                     $time, e.clamp, out_value_clamped);
          end
          if (out_empty_error !== e.empty) begin
            err_count++;
            $display("%0t: empty_error mismatch: expected %b, actual %b",
                     $time, e.empty, out_empty_error);
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_format_spec_parser_top failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
